@@ sv/cte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cte_pkg
// shared codes and field widths of the adjacency store
// ----------------------------------------------------------------------------
package cte_pkg;
   localparam int ACTION_BITS = 3;
   localparam int VERTEX_BITS = 10;
   localparam int OFFSET_BITS = 12;
   localparam int STATUS_BITS = 3;
   localparam int DEGREE_BITS = 13;
   localparam int COUNT_BITS  = 13;
   localparam int VCOUNT_BITS = 11;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 13'h1fff;

   localparam logic [ACTION_BITS-1:0] ACT_APPEND  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DELETE  = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_REVERT  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_MATCH   = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_COMPACT = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_READ    = 3'd5;

   localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_RANGE   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_DELETED = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_LIVE    = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;
endpackage
`default_nettype wire

@@ sv/csr_tombstone_edge_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csr_tombstone_edge_store
// compressed sparse row adjacency store with tombstone deletion
// ----------------------------------------------------------------------------
// channel | dir | beat
// req_    | in  | tdata = action, vertex, offset, neighbor, edge_data
// rsp_    | out | tdata = status, neighbor_out, edge_data_out, degree_out, count
// csr_    | in  | apb write/read of vertex_count
// delete, revert and read pass through table read, memory read, write back and
// answer after acceptance; append skips the memory read, and range errors found
// at the table read go straight to the answer. match reads and compares each
// entry of the list in turn; compact walks every active vertex and its entries,
// then makes a second vertex pass for starts. one beat at a time; the next beat
// is taken in the cycle after the result leaves, and a waiting result holds off req.
// reset clears the degree table with a sweep over every vertex entry, req held off.
module csr_tombstone_edge_store #(
   parameter int VERTICES      = 1024,
   parameter int EDGES         = 4096,
   parameter int NEIGHBOR_BITS = 32,
   parameter int DATA_BITS     = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[2:0] vertex[12:3] offset[24:13] neighbor[56:25] edge_data[88:57]
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[2:0] neighbor_out[34:3] edge_data_out[66:35] degree_out[79:67]
   // count[92:80]
   output logic [95:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import cte_pkg::*;
   localparam int VA = $clog2(VERTICES);
   localparam int EA = $clog2(EDGES);
   localparam logic [NEIGHBOR_BITS-1:0] TOMB = '1;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_PT_T, S_PT_M, S_PT_W, S_MT_R, S_MT_C, S_CP_V, S_CP_T,
      S_CP_R, S_CP_C, S_CP_D, S_SU_V, S_SU_T, S_OUT
   } state_type;

   // memories
   logic [DEGREE_BITS-1:0]   deg_mem [VERTICES];
   logic [DEGREE_BITS-1:0]   start_mem [VERTICES];
   logic [NEIGHBOR_BITS-1:0] nbr_mem [EDGES];
   logic [DATA_BITS-1:0]     dat_mem [EDGES];

   state_type state_ff;
   logic [VCOUNT_BITS-1:0] vcount_ff;
   logic [DEGREE_BITS-1:0] tail_ff;
   logic [VERTEX_BITS-1:0] last_ff;
   logic [ACTION_BITS-1:0] act_ff;
   logic [VERTEX_BITS-1:0] v_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [NEIGHBOR_BITS-1:0] nin_ff;
   logic [DATA_BITS-1:0]   din_ff;
   logic [16:0] vi_ff;
   logic [DEGREE_BITS-1:0] k_ff, deg_ff, kept_ff;
   logic [DEGREE_BITS-1:0] base_ff;
   logic [20:0] wp_ff, sum_ff;
   logic [COUNT_BITS-1:0] cnt_ff;
   logic [STATUS_BITS-1:0] st_ff;
   logic [NEIGHBOR_BITS-1:0] nout_ff;
   logic [DATA_BITS-1:0] dout_ff;
   logic [DEGREE_BITS-1:0] dgo_ff;

   // memory ports, read data registered
   logic              dw_en, sw_en, nw_en, mw_en;
   logic [VA-1:0]     d_addr;
   logic [DEGREE_BITS-1:0] dw_data, sw_data, d_q, s_q;
   logic [EA-1:0]     n_raddr, n_waddr;
   logic [NEIGHBOR_BITS-1:0] nw_data, n_q;
   logic [DATA_BITS-1:0] mw_data, m_q;

   always_ff @(posedge clock) begin
      if (dw_en) deg_mem[d_addr] <= dw_data;
      if (sw_en) start_mem[d_addr] <= sw_data;
      d_q <= deg_mem[d_addr];
      s_q <= start_mem[d_addr];
      if (nw_en) nbr_mem[n_waddr] <= nw_data;
      if (mw_en) dat_mem[n_waddr] <= mw_data;
      n_q <= nbr_mem[n_raddr];
      m_q <= dat_mem[n_raddr];
   end

   logic [VCOUNT_BITS-1:0] vc_eff;
   logic [16:0] vc_act;
   assign vc_act = (32'(vcount_ff) > VERTICES) ? 17'(VERTICES) : 17'(vcount_ff);
   assign vc_eff = vcount_ff;
   logic in_range;
   assign in_range = 17'(v_ff) < vc_act;
   logic [EA-1:0] pt_addr;
   assign pt_addr = EA'(base_ff + DEGREE_BITS'(off_ff));

   // csr port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(vc_eff) : 32'd0;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {3'd0, cnt_ff, dgo_ff, 32'(dout_ff), 32'(nout_ff), st_ff};

   // memory control
   always_comb begin
      dw_en = 1'b0; sw_en = 1'b0; nw_en = 1'b0; mw_en = 1'b0;
      d_addr = VA'(v_ff); dw_data = '0; sw_data = '0;
      n_raddr = EA'(base_ff + k_ff); n_waddr = EA'(base_ff + k_ff);
      nw_data = TOMB; mw_data = m_q;
      case (state_ff)
         S_CLR: begin
            d_addr = VA'(vi_ff); dw_en = 1'b1;
         end
         S_IDLE: d_addr = VA'(req_tdata[12:3]);
         S_PT_T: n_raddr = EA'(s_q + DEGREE_BITS'(off_ff));
         S_PT_W: begin
            n_waddr = pt_addr;
            if (act_ff == ACT_APPEND) begin
               n_waddr = EA'(tail_ff); nw_data = nin_ff; mw_data = din_ff;
               if (st_ff == ST_OK) begin
                  nw_en = 1'b1; mw_en = 1'b1; dw_en = 1'b1;
                  dw_data = deg_ff + 1'b1;
                  sw_en = (deg_ff == '0); sw_data = tail_ff;
               end
            end else if (act_ff == ACT_DELETE) begin
               nw_en = (st_ff == ST_OK);
            end else if (act_ff == ACT_REVERT) begin
               nw_data = nin_ff; nw_en = (st_ff == ST_OK);
            end
         end
         S_MT_C: nw_en = (n_q != TOMB) && (n_q == nin_ff);
         S_MT_R: n_raddr = EA'(base_ff + k_ff);
         S_CP_V: d_addr = VA'(vi_ff);
         S_CP_R: n_raddr = EA'(base_ff + k_ff);
         S_CP_C: begin
            n_waddr = EA'(wp_ff); nw_data = n_q; mw_data = m_q;
            nw_en = (n_q != TOMB); mw_en = (n_q != TOMB);
         end
         S_CP_D: begin
            d_addr = VA'(vi_ff); dw_en = 1'b1; dw_data = kept_ff;
         end
         S_SU_V: d_addr = VA'(vi_ff);
         S_SU_T: begin
            d_addr = VA'(vi_ff); sw_en = 1'b1; sw_data = DEGREE_BITS'(sum_ff);
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; vi_ff <= '0; vcount_ff <= '0; tail_ff <= '0;
         last_ff <= '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
            vcount_ff <= csr_pwdata[VCOUNT_BITS-1:0];
         case (state_ff)
            S_CLR: begin
               vi_ff <= vi_ff + 1'b1;
               if (vi_ff == 17'(VERTICES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_tvalid) begin
               act_ff <= req_tdata[2:0]; v_ff <= req_tdata[12:3];
               off_ff <= req_tdata[24:13];
               nin_ff <= NEIGHBOR_BITS'(req_tdata[56:25]);
               din_ff <= DATA_BITS'(req_tdata[88:57]);
               st_ff <= ST_OK; nout_ff <= '0; dout_ff <= '0; cnt_ff <= '0;
               vi_ff <= '0; wp_ff <= '0; sum_ff <= '0;
               state_ff <= (req_tdata[2:0] == ACT_COMPACT) ? S_CP_V : S_PT_T;
            end
            S_PT_T: begin
               deg_ff <= d_q; base_ff <= s_q; k_ff <= '0;
               dgo_ff <= in_range ? d_q : '0;
               if (act_ff > ACT_READ || !in_range) begin
                  st_ff <= ST_RANGE; state_ff <= S_OUT;
               end else if (act_ff == ACT_APPEND) begin
                  if (tail_ff >= DEGREE_BITS'(EDGES) || v_ff < last_ff ||
                      (d_q != '0 && s_q + d_q != tail_ff))
                     st_ff <= ST_FULL;
                  state_ff <= S_PT_W;
               end else if (act_ff == ACT_MATCH) begin
                  state_ff <= (d_q == '0) ? S_OUT : S_MT_R;
               end else if (DEGREE_BITS'(off_ff) >= d_q) begin
                  st_ff <= ST_RANGE; state_ff <= S_OUT;
               end else state_ff <= S_PT_M;
            end
            S_PT_M: begin
               if (act_ff == ACT_DELETE && n_q == TOMB) st_ff <= ST_DELETED;
               if (act_ff == ACT_REVERT && n_q != TOMB) st_ff <= ST_LIVE;
               if (act_ff == ACT_READ) begin
                  nout_ff <= n_q; dout_ff <= m_q;
               end
               state_ff <= S_PT_W;
            end
            S_PT_W: begin
               if (act_ff == ACT_APPEND && st_ff == ST_OK) begin
                  tail_ff <= tail_ff + 1'b1; last_ff <= v_ff;
                  dgo_ff <= deg_ff + 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_MT_R: state_ff <= S_MT_C;
            S_MT_C: begin
               if (n_q != TOMB && n_q == nin_ff && cnt_ff != COUNT_MAX)
                  cnt_ff <= cnt_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == deg_ff) ? S_OUT : S_MT_R;
            end
            S_CP_V: state_ff <= (vi_ff < vc_act) ? S_CP_T : S_SU_V;
            S_CP_T: begin
               deg_ff <= d_q; base_ff <= s_q; k_ff <= '0; kept_ff <= '0;
               state_ff <= (d_q == '0) ? S_CP_D : S_CP_R;
            end
            S_CP_R: state_ff <= S_CP_C;
            S_CP_C: begin
               if (n_q != TOMB) begin
                  wp_ff <= wp_ff + 1'b1; kept_ff <= kept_ff + 1'b1;
               end else if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff + 1'b1 == deg_ff) ? S_CP_D : S_CP_R;
            end
            S_CP_D: begin
               if (vi_ff + 1'b1 >= vc_act) begin
                  vi_ff <= '0; state_ff <= S_SU_V;
               end else begin
                  vi_ff <= vi_ff + 1'b1; state_ff <= S_CP_V;
               end
            end
            S_SU_V: state_ff <= (vi_ff < vc_act) ? S_SU_T : S_OUT;
            S_SU_T: begin
               sum_ff <= sum_ff + 21'(d_q); vi_ff <= vi_ff + 1'b1;
               state_ff <= S_SU_V;
               if (act_ff == ACT_COMPACT && 17'(v_ff) == vi_ff) dgo_ff <= d_q;
            end
            S_OUT: begin
               if (act_ff == ACT_COMPACT && state_ff == S_OUT && rsp_tready)
                  state_ff <= S_IDLE;
               else if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_SU_V && !(vi_ff < vc_act)) begin
            tail_ff <= (sum_ff > 21'(EDGES)) ? DEGREE_BITS'(EDGES)
                                              : DEGREE_BITS'(sum_ff);
            if (!in_range) dgo_ff <= '0;
         end
         if (state_ff == S_IDLE && req_tvalid) dgo_ff <= '0;
      end
   end
endmodule
`default_nettype wire

@@ sv/cte_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cte_checker
// port-level checks of the adjacency store
// ----------------------------------------------------------------------------
module cte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [95:0] rsp_tdata,
   input wire logic        csr_pready
);
   import cte_pkg::*;
   // one beat at a time: no request taken while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("req ready with result pending");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // status stays within its codes
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_FULL) else $error("bad status");
   // accepted request leads to no result in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid) else $error("result too early");
   a_rdy: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind csr_tombstone_edge_store cte_checker u_cte_checker (.*);
`default_nettype wire

@@ bench/tb_csr_tombstone_edge_store.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csr_tombstone_edge_store
// self-checking bench for the compressed sparse row adjacency store: every
// request beat is run through a local model of the tables and memories and
// each response beat is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_csr_tombstone_edge_store;
   import cte_pkg::*;

   localparam int NUM_VERTICES = 1024;
   localparam int NUM_EDGES    = 4096;
   localparam int LONG_LIST    = 400;
   localparam logic [31:0] TOMB = 32'hffff_ffff;
   localparam logic [ACTION_BITS-1:0] ACT_BAD_6 = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_BAD_7 = 3'd7;
   localparam logic [1:0] ADDR_VERTEX_COUNT = 2'd0;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [31:0]            neighbor_out;
      logic [31:0]            edge_data_out;
      logic [DEGREE_BITS-1:0] degree_out;
      logic [COUNT_BITS-1:0]  count;
   } answer_t;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [95:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   // model state of the store
   logic [DEGREE_BITS-1:0] deg_tbl [NUM_VERTICES];
   logic [DEGREE_BITS-1:0] start_tbl [NUM_VERTICES];
   logic [31:0]            nbr_mem [NUM_EDGES];
   logic [31:0]            dat_mem [NUM_EDGES];
   int                     tail_ptr;
   int                     last_vertex;
   logic [VCOUNT_BITS-1:0] vcount_reg;

   answer_t     pending_answers[$];
   int          failures;
   bit          steady;
   logic [31:0] nbr_pool [8];

   csr_tombstone_edge_store u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Test completed with failures");
      $finish;
   end

   // model of one request; updates the tables and returns the answer
   function automatic answer_t store_step(logic [2:0] act, logic [9:0] v,
                                          logic [11:0] off, logic [31:0] nbr,
                                          logic [31:0] dat);
      answer_t ans;
      int vc, wp, removed, sum, deg, hits, a;
      bit in_range;
      ans = '0;
      vc = (vcount_reg > NUM_VERTICES) ? NUM_VERTICES : int'(vcount_reg);
      in_range = int'(v) < vc;
      if (act == ACT_COMPACT) begin
         wp = 0;
         removed = 0;
         sum = 0;
         for (int i = 0; i < vc; i++) begin
            deg = int'(deg_tbl[i]);
            for (int k = 0; k < deg; k++) begin
               a = (int'(start_tbl[i]) + k) % NUM_EDGES;
               if (nbr_mem[a] != TOMB) begin
                  nbr_mem[wp % NUM_EDGES] = nbr_mem[a];
                  dat_mem[wp % NUM_EDGES] = dat_mem[a];
                  wp++;
               end else begin
                  deg_tbl[i] = deg_tbl[i] - 1'b1;
                  removed++;
               end
            end
         end
         for (int i = 0; i < vc; i++) begin
            start_tbl[i] = DEGREE_BITS'(sum);
            sum += int'(deg_tbl[i]);
         end
         tail_ptr = (sum > NUM_EDGES) ? NUM_EDGES : sum;
         ans.count = COUNT_BITS'((removed > int'(COUNT_MAX)) ? int'(COUNT_MAX) : removed);
      end else if (act > ACT_READ || !in_range) begin
         ans.status = ST_RANGE;
      end else if (act == ACT_APPEND) begin
         deg = int'(deg_tbl[v]);
         if (tail_ptr >= NUM_EDGES || int'(v) < last_vertex ||
             (deg != 0 && int'(start_tbl[v]) + deg != tail_ptr)) begin
            ans.status = ST_FULL;
         end else begin
            if (deg == 0) start_tbl[v] = DEGREE_BITS'(tail_ptr);
            nbr_mem[tail_ptr % NUM_EDGES] = nbr;
            dat_mem[tail_ptr % NUM_EDGES] = dat;
            deg_tbl[v] = DEGREE_BITS'(deg + 1);
            tail_ptr++;
            last_vertex = int'(v);
         end
      end else if (act == ACT_MATCH) begin
         hits = 0;
         for (int k = 0; k < int'(deg_tbl[v]); k++) begin
            a = (int'(start_tbl[v]) + k) % NUM_EDGES;
            if (nbr_mem[a] != TOMB && nbr_mem[a] == nbr) begin
               nbr_mem[a] = TOMB;
               hits++;
            end
         end
         ans.count = COUNT_BITS'((hits > int'(COUNT_MAX)) ? int'(COUNT_MAX) : hits);
      end else if (DEGREE_BITS'(off) >= deg_tbl[v]) begin
         ans.status = ST_RANGE;
      end else begin
         a = (int'(start_tbl[v]) + int'(off)) % NUM_EDGES;
         if (act == ACT_DELETE) begin
            if (nbr_mem[a] == TOMB) ans.status = ST_DELETED;
            else nbr_mem[a] = TOMB;
         end else if (act == ACT_REVERT) begin
            if (nbr_mem[a] != TOMB) ans.status = ST_LIVE;
            else nbr_mem[a] = nbr;
         end else begin
            ans.neighbor_out  = nbr_mem[a];
            ans.edge_data_out = dat_mem[a];
         end
      end
      ans.degree_out = in_range ? deg_tbl[v] : '0;
      return ans;
   endfunction

   // send one request beat; the prediction is taken at acceptance
   task automatic send_req(logic [2:0] act, logic [9:0] v, logic [11:0] off,
                           logic [31:0] nbr, logic [31:0] dat);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, dat, nbr, off, v, act};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(store_step(act, v, off, nbr, dat));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(logic [VCOUNT_BITS-1:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_VERTEX_COUNT;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      vcount_reg = value;
   endtask

   function automatic logic [31:0] pick_neighbor();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return nbr_pool[$urandom_range(0, 7)];
      if (r < 80) return TOMB;
      return $urandom;
   endfunction

   // response checker
   always @(posedge clock) begin
      answer_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("response beat with no request outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d got %0d", want.status, rsp_tdata[2:0]);
               failures++;
            end
            if (rsp_tdata[34:3] !== want.neighbor_out) begin
               $error("neighbor_out: expected %h got %h", want.neighbor_out,
                      rsp_tdata[34:3]);
               failures++;
            end
            if (rsp_tdata[66:35] !== want.edge_data_out) begin
               $error("edge_data_out: expected %h got %h", want.edge_data_out,
                      rsp_tdata[66:35]);
               failures++;
            end
            if (rsp_tdata[79:67] !== want.degree_out) begin
               $error("degree_out: expected %0d got %0d", want.degree_out,
                      rsp_tdata[79:67]);
               failures++;
            end
            if (rsp_tdata[92:80] !== want.count) begin
               $error("count: expected %0d got %0d", want.count, rsp_tdata[92:80]);
               failures++;
            end
         end
      end
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 37);
   end

   // each error status on a tiny store
   task automatic test_directed();
      send_req(ACT_APPEND, 10'd0, 12'd0, 32'd1, 32'd2);
      send_req(ACT_COMPACT, 10'd0, 12'd0, 32'd0, 32'd0);
      write_vertex_count(11'd4);
      send_req(ACT_APPEND, 10'd0, 12'd0, 32'd0, 32'hffff_ffff);
      send_req(ACT_APPEND, 10'd0, 12'd0, TOMB, 32'd0);
      send_req(ACT_APPEND, 10'd0, 12'd0, nbr_pool[0], 32'h5a5a_a5a5);
      send_req(ACT_APPEND, 10'd2, 12'd0, nbr_pool[0], 32'h1234_5678);
      send_req(ACT_APPEND, 10'd1, 12'd0, nbr_pool[1], 32'd7);
      send_req(ACT_APPEND, 10'd0, 12'd0, nbr_pool[1], 32'd7);
      send_req(ACT_READ, 10'd0, 12'd2, 32'd0, 32'd0);
      send_req(ACT_READ, 10'd0, 12'd3, 32'd0, 32'd0);
      send_req(ACT_DELETE, 10'd0, 12'd0, 32'd0, 32'd0);
      send_req(ACT_DELETE, 10'd0, 12'd0, 32'd0, 32'd0);
      send_req(ACT_REVERT, 10'd0, 12'd2, nbr_pool[2], 32'd0);
      send_req(ACT_REVERT, 10'd0, 12'd0, nbr_pool[0], 32'd0);
      send_req(ACT_MATCH, 10'd0, 12'd0, TOMB, 32'd0);
      send_req(ACT_MATCH, 10'd0, 12'd0, nbr_pool[0], 32'd0);
      send_req(ACT_READ, 10'd3, 12'd0, 32'd0, 32'd0);
      send_req(ACT_READ, 10'd1023, 12'hfff, 32'd0, 32'd0);
      send_req(ACT_BAD_6, 10'd0, 12'd0, 32'd0, 32'd0);
      send_req(ACT_BAD_7, 10'd2, 12'd0, 32'd0, 32'd0);
      send_req(ACT_COMPACT, 10'd0, 12'd0, 32'd0, 32'd0);
      send_req(ACT_READ, 10'd2, 12'd0, 32'd0, 32'd0);
   endtask

   // mostly well-formed traffic around the live lists, some noise
   task automatic test_random(int n_items, int steady_from, int steady_to);
      int r, v, deg;
      logic [11:0] off;
      for (int i = 0; i < n_items; i++) begin
         steady = (i >= steady_from && i < steady_to);
         if (i == n_items / 2) drain();
         r = $urandom_range(0, 99);
         if (r < 35) begin
            v = last_vertex + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
            if (v > NUM_VERTICES - 2) v = NUM_VERTICES - 2;
            send_req(ACT_APPEND, 10'(v), 12'($urandom), pick_neighbor(), $urandom);
         end else if (r < 80) begin
            v = $urandom_range(0, last_vertex + 1);
            deg = int'(deg_tbl[v]);
            off = 12'((deg == 0 || $urandom_range(0, 9) == 0) ?
                      $urandom_range(0, deg + 2) : $urandom_range(0, deg - 1));
            case ($urandom_range(0, 2))
               0: send_req(ACT_DELETE, 10'(v), off, $urandom, $urandom);
               1: send_req(ACT_REVERT, 10'(v), off, pick_neighbor(), $urandom);
               default: send_req(ACT_READ, 10'(v), off, $urandom, $urandom);
            endcase
         end else if (r < 88) begin
            send_req(ACT_MATCH, 10'($urandom_range(0, last_vertex)), 12'($urandom),
                     pick_neighbor(), $urandom);
         end else if (r < 91) begin
            send_req(ACT_COMPACT, 10'($urandom), 12'($urandom), $urandom, $urandom);
         end else begin
            case ($urandom_range(0, 5))
               0: send_req(ACT_DELETE, 10'($urandom), 12'($urandom), $urandom,
                           $urandom);
               1: send_req(ACT_REVERT, 10'($urandom), 12'($urandom), $urandom,
                           $urandom);
               2: send_req(ACT_MATCH, 10'($urandom), 12'($urandom), $urandom,
                           $urandom);
               3: send_req(ACT_READ, 10'($urandom), 12'($urandom), $urandom,
                           $urandom);
               4: send_req(ACT_BAD_6, 10'($urandom), 12'($urandom), $urandom,
                           $urandom);
               default: send_req(ACT_BAD_7, 10'($urandom), 12'($urandom), $urandom,
                                 $urandom);
            endcase
         end
      end
      steady = 1'b0;
   endtask

   // the top vertex gets one long list from an emptied store
   task automatic test_long_list();
      write_vertex_count(11'd0);
      send_req(ACT_COMPACT, 10'd0, 12'd0, 32'd0, 32'd0);
      write_vertex_count(11'd1024);
      for (int i = 0; i < LONG_LIST; i++)
         send_req(ACT_APPEND, 10'd1023, 12'd0,
                  ($urandom_range(0, 9) == 0) ? pick_neighbor() : nbr_pool[3],
                  $urandom);
      send_req(ACT_READ, 10'd1023, 12'hfff, 32'd0, 32'd0);
      send_req(ACT_READ, 10'd1023, 12'd0, 32'd0, 32'd0);
      send_req(ACT_DELETE, 10'd1023, 12'hfff, 32'd0, 32'd0);
      send_req(ACT_MATCH, 10'd1023, 12'd0, nbr_pool[3], 32'd0);
      send_req(ACT_COMPACT, 10'd0, 12'd0, 32'd0, 32'd0);
      send_req(ACT_READ, 10'd1023, 12'd0, 32'd0, 32'd0);
   endtask

   initial begin
      failures = 0;
      steady = 1'b0;
      tail_ptr = 0;
      last_vertex = 0;
      vcount_reg = '0;
      for (int i = 0; i < NUM_VERTICES; i++) begin
         deg_tbl[i] = '0;
         start_tbl[i] = '0;
      end
      for (int i = 0; i < NUM_EDGES; i++) begin
         nbr_mem[i] = '0;
         dat_mem[i] = '0;
      end
      foreach (nbr_pool[i]) nbr_pool[i] = $urandom;
      nbr_pool[7] = 32'd0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      write_vertex_count(11'd16);
      test_random(400, 80, 160);
      write_vertex_count(11'd5);
      test_random(100, 0, 0);
      write_vertex_count(11'd2047);
      test_random(600, 200, 400);
      test_long_list();

      drain();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
